@@ src/erq_pkg.sv @@
// Shared types and constants for the epoch retire queue reclaimer.
package erq_pkg;

  typedef enum logic [1:0] {
    OP_ADVANCE = 2'd0,
    OP_RETIRE  = 2'd1,
    OP_CLEAN   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_EPOCH      = 3'd0,
    K_RETIRE_OK  = 3'd1,
    K_RETIRE_FULL = 3'd2,
    K_FREED      = 3'd3,
    K_NONE_FREED = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADV,
    S_RET,
    S_CRD,
    S_CCMP,
    S_CDEC,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  thr;
    logic [31:0] handle;
  } req_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic        last;
  } rsp_t;

  localparam int MAX_RESULTS = 64;
  localparam logic [2:0] ADDR_ACTIVE_THREADS = 3'd0;
  localparam logic [3:0] ACTIVE_RESET = 4'd8;

endpackage

@@ src/erq_ram.sv @@
// Generic single-port-write, registered-read RAM.
module erq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/epoch_retire_queue_reclaimer_top.sv @@
// Top level of the epoch retire queue reclaimer.
// Per-thread epoch counters and retire FIFOs; each retired handle is stored with a snapshot
// of all counters in one RAM. One request is worked at a time. A clean examines entries in
// turn (each freed entry and the one that stops the walk), each through the RAM read, the
// registered snapshot compare and the pointer update of that entry. A stalled result
// channel adds its stall. A new request is taken while the last result still waits in the
// output register.
module epoch_retire_queue_reclaimer_top
  import erq_pkg::*;
#(
  parameter int THREADS       = 8,
  parameter int QUEUE_DEPTH   = 64,
  parameter int COUNTER_WIDTH = 32,
  parameter int HANDLE_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int AW = TW + QW;
  localparam int SNAP_W = THREADS * COUNTER_WIDTH;
  localparam int ENTRY_W = SNAP_W + HANDLE_WIDTH;
  localparam logic [QW:0] FULL = (QW + 1)'(QUEUE_DEPTH);
  localparam logic [QW-1:0] QLAST = QW'(QUEUE_DEPTH - 1);
  localparam logic [6:0] KMAX = 7'(MAX_RESULTS);
  localparam logic [5:0] NTHREADS = 6'(THREADS);

  function automatic logic [TW-1:0] thread_of(input logic [2:0] tid);
    logic [5:0] x;
    x = {3'b000, tid};
    for (int i = 0; i < 8; i++) begin
      if (x >= NTHREADS) x = x - NTHREADS;
    end
    return x[TW-1:0];
  endfunction

  logic [COUNTER_WIDTH-1:0] counters [THREADS];
  logic [QW-1:0]            rptr [THREADS];
  logic [QW-1:0]            wptr [THREADS];
  logic [QW:0]              fill [THREADS];
  logic [3:0]               active_threads;

  state_t state, state_next;
  logic [1:0]             op;
  logic [TW-1:0]          tsel;
  logic [HANDLE_WIDTH-1:0] hreg;
  logic [6:0]             kcnt;
  logic                   pend;
  logic [HANDLE_WIDTH-1:0] pend_h;
  logic                   pass_q;
  logic [HANDLE_WIDTH-1:0] cand_h;

  logic                   slot_free;
  logic                   out_load;
  rsp_t                   out_d;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]     ram_wdata, ram_rdata;
  logic [SNAP_W-1:0]      snap_now;
  logic                   pass_c;
  logic [5:0]             nact;
  logic [63:0]            h64_in, h64_out, c64_out;
  logic [COUNTER_WIDTH-1:0] cnt_inc;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_ACTIVE_THREADS) ? {28'd0, active_threads} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_threads <= ACTIVE_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_ACTIVE_THREADS) begin
      active_threads <= pwdata[3:0];
    end
  end

  always_comb begin
    if (active_threads == 4'd0) nact = 6'd1;
    else if ({2'b00, active_threads} > NTHREADS) nact = NTHREADS;
    else nact = {2'b00, active_threads};
  end

  always_comb begin
    for (int i = 0; i < THREADS; i++) begin
      snap_now[i*COUNTER_WIDTH +: COUNTER_WIDTH] = counters[i];
    end
  end

  // every active thread must have moved strictly past its snapshot (mod 2^W, half range)
  always_comb begin
    logic [COUNTER_WIDTH-1:0] d;
    pass_c = 1'b1;
    for (int i = 0; i < THREADS; i++) begin
      d = counters[i] - ram_rdata[HANDLE_WIDTH + i*COUNTER_WIDTH +: COUNTER_WIDTH];
      if (6'(i) < nact && (d == '0 || d[COUNTER_WIDTH-1])) pass_c = 1'b0;
    end
  end

  assign h64_in  = 64'(req.handle);
  assign h64_out = 64'(pend_h);
  assign cnt_inc = counters[tsel] + COUNTER_WIDTH'(1);
  assign c64_out = 64'(cnt_inc);
  assign slot_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  assign ram_waddr = {tsel, wptr[tsel]};
  assign ram_raddr = {tsel, rptr[tsel]};
  assign ram_wdata = {snap_now, hreg};

  erq_ram #(.WIDTH(ENTRY_W), .DEPTH(1 << AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    out_d      = '{kind: K_NONE_FREED, value: 32'd0, last: 1'b1};
    ram_we     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (req.opcode)
            OP_ADVANCE: state_next = S_ADV;
            OP_RETIRE:  state_next = S_RET;
            OP_CLEAN:   state_next = S_CRD;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_ADV: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_d      = '{kind: K_EPOCH, value: c64_out[31:0], last: 1'b1};
          state_next = S_IDLE;
        end
      end
      S_RET: begin
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          if (fill[tsel] >= FULL) begin
            out_d = '{kind: K_RETIRE_FULL, value: 32'd0, last: 1'b1};
          end else begin
            ram_we = 1'b1;
            out_d  = '{kind: K_RETIRE_OK, value: 32'd0, last: 1'b1};
          end
        end
      end
      S_CRD: begin
        if (fill[tsel] == '0 || kcnt == KMAX) state_next = S_FIN;
        else state_next = S_CCMP;
      end
      S_CCMP: state_next = S_CDEC;
      S_CDEC: begin
        if (!pass_q) begin
          state_next = S_FIN;
        end else if (!pend || slot_free) begin
          if (pend) begin
            out_load = 1'b1;
            out_d    = '{kind: K_FREED, value: h64_out[31:0], last: 1'b0};
          end
          state_next = S_CRD;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
          if (pend) out_d = '{kind: K_FREED, value: h64_out[31:0], last: 1'b1};
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) rsp <= out_d;
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      op   <= req.opcode;
      tsel <= thread_of(req.thr);
      hreg <= h64_in[HANDLE_WIDTH-1:0];
    end
    if (state == S_CCMP) begin
      pass_q <= pass_c;
      cand_h <= ram_rdata[HANDLE_WIDTH-1:0];
    end
    if (state == S_CDEC && pass_q && (!pend || slot_free)) pend_h <= cand_h;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kcnt <= '0;
      pend <= 1'b0;
    end else if (state == S_IDLE) begin
      kcnt <= '0;
      pend <= 1'b0;
    end else if (state == S_CDEC && pass_q && (!pend || slot_free)) begin
      kcnt <= kcnt + 7'd1;
      pend <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < THREADS; i++) begin
        counters[i] <= '0;
        rptr[i]     <= '0;
        wptr[i]     <= '0;
        fill[i]     <= '0;
      end
    end else begin
      if (state == S_ADV && slot_free && op == OP_ADVANCE) counters[tsel] <= cnt_inc;
      if (ram_we) begin
        wptr[tsel] <= (wptr[tsel] == QLAST) ? '0 : wptr[tsel] + QW'(1);
        fill[tsel] <= fill[tsel] + (QW + 1)'(1);
      end
      if (state == S_CDEC && pass_q && (!pend || slot_free)) begin
        rptr[tsel] <= (rptr[tsel] == QLAST) ? '0 : rptr[tsel] + QW'(1);
        fill[tsel] <= fill[tsel] - (QW + 1)'(1);
      end
    end
  end

endmodule

@@ src/erq_checker.sv @@
// Port-level checks on the result channel of the reclaimer, with bind.
module erq_checker
  import erq_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.kind <= K_NONE_FREED)
    else $error("bad result kind");

  a_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.kind != K_FREED |-> rsp.last)
    else $error("single-result kind without last");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.kind == K_RETIRE_OK || rsp.kind == K_RETIRE_FULL ||
                  rsp.kind == K_NONE_FREED) |-> rsp.value == 32'd0)
    else $error("nonzero value on status result");

endmodule

bind epoch_retire_queue_reclaimer_top erq_checker u_erq_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
